// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the int4 grouped dot product block.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/i4gsdp_pkg.sv =====
// Package for the int4 grouped scaled dot product block: constants, types, states.
// No dependencies.
`default_nettype none
package i4gsdp_pkg;

    localparam int LANES     = 4;
    localparam int ACT_W     = 8;
    localparam int NIB_W     = 4;
    localparam int GC_W      = 7;
    localparam int GC_MAX    = 64;
    localparam int CHUNK_K   = 64;
    localparam int CNT_W     = 10;
    localparam int PG_W      = CNT_W + 1;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = QPTR_W + 1;
    localparam int MW        = 94;
    localparam int EW        = 12;
    localparam int ZERO_LSB  = -600;
    localparam int PADDR_W   = 3;

    localparam logic [0:0]  REG_GROUP_CHUNKS = 1'b0;
    localparam logic [GC_W-1:0] GC_RESET     = 7'd1;
    localparam logic [31:0] QNAN32           = 32'h7FC0_0000;
    localparam logic [31:0] POS_INF32        = 32'h7F80_0000;

    typedef struct packed {
        logic [31:0] int_sum;
        logic [15:0] group_scale;
        logic [31:0] row_scale;
        logic        last;
    } t_drain;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } t_q_stat;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_PROD,
        BK_ALIGN,
        BK_ADD,
        BK_NEG,
        BK_NORM,
        BK_DENORM,
        BK_PACK,
        BK_DONE,
        BK_MULP
    } t_bk_state;

endpackage
`default_nettype wire

// ===== rtl/i4gsdp_front.sv =====
// Front end: integer MAC over one chunk per beat, group counting, drain requests.
// Depends on i4gsdp_pkg.
`default_nettype none
module i4gsdp_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [7:0]              i_act0,
    input  logic signed [7:0]              i_act1,
    input  logic signed [7:0]              i_act2,
    input  logic signed [7:0]              i_act3,
    input  logic [3:0]                     i_wnib0,
    input  logic [3:0]                     i_wnib1,
    input  logic [3:0]                     i_wnib2,
    input  logic [3:0]                     i_wnib3,
    input  logic [15:0]                    i_group_scale,
    input  logic [31:0]                    i_row_scale,
    input  logic                           i_last_chunk,
    input  logic [i4gsdp_pkg::GC_W-1:0]    i_group_chunks,
    input  logic                           i_full,
    output logic                           o_push,
    output i4gsdp_pkg::t_drain             o_entry
);
    import i4gsdp_pkg::*;

    logic [31:0]             r_int_sum, n_int_sum;
    logic [CNT_W-1:0]        r_count, n_count;
    logic signed [11:0]      w_p0, w_p1, w_p2, w_p3;
    logic signed [13:0]      w_dot;
    logic [31:0]             w_sum;
    logic [GC_W-1:0]         w_g;
    logic [PG_W-1:0]         w_per_group;
    logic [PG_W-1:0]         w_cnt_next;
    logic                    w_close;
    logic                    w_accept;

    // nibble is plain 4-bit two's complement
    assign w_p0  = i_act0 * $signed(i_wnib0);
    assign w_p1  = i_act1 * $signed(i_wnib1);
    assign w_p2  = i_act2 * $signed(i_wnib2);
    assign w_p3  = i_act3 * $signed(i_wnib3);
    assign w_dot = 14'(w_p0) + 14'(w_p1) + 14'(w_p2) + 14'(w_p3);
    assign w_sum = r_int_sum + 32'(w_dot);

    assign w_g = (i_group_chunks == '0) ? GC_W'(1) :
                 (i_group_chunks > GC_W'(GC_MAX)) ? GC_W'(GC_MAX) : i_group_chunks;
    assign w_per_group = PG_W'(w_g) * PG_W'(CHUNK_K / LANES);
    assign w_cnt_next  = PG_W'(r_count) + PG_W'(1);
    assign w_close     = (w_cnt_next >= w_per_group) || i_last_chunk;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && w_close;

    assign o_entry.int_sum     = w_sum;
    assign o_entry.group_scale = i_group_scale;
    assign o_entry.row_scale   = i_row_scale;
    assign o_entry.last        = i_last_chunk;

    always_comb begin
        n_int_sum = r_int_sum;
        n_count   = r_count;
        if (w_accept) begin
            if (w_close) begin
                n_int_sum = '0;
                n_count   = '0;
            end else begin
                n_int_sum = w_sum;
                n_count   = w_cnt_next[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_sum <= '0;
            r_count   <= '0;
        end else begin
            r_int_sum <= n_int_sum;
            r_count   <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/i4gsdp_fifo.sv =====
// Short drain queue between front and back end.
// Depends on i4gsdp_pkg.
`default_nettype none
module i4gsdp_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  i4gsdp_pkg::t_drain    i_entry,
    input  logic                  i_pop,
    output i4gsdp_pkg::t_drain    o_entry,
    output i4gsdp_pkg::t_q_stat   o_stat
);
    import i4gsdp_pkg::*;

    t_drain              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QCNT_W-1:0]   r_cnt;

    assign o_entry      = r_mem[r_rp];
    assign o_stat.count = r_cnt;
    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/i4gsdp_back.sv =====
// Back end: sequenced float engine for the group FMA and the final row-scale multiply.
// Depends on i4gsdp_pkg.
`default_nettype none
module i4gsdp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_pop,
    input  i4gsdp_pkg::t_drain i_entry,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_result,
    output logic               o_busy
);
    import i4gsdp_pkg::*;

    t_bk_state                r_state, n_state;
    t_drain                   r_ent, n_ent;
    logic [31:0]              r_fsum, n_fsum;
    logic                     r_is_mul, n_is_mul;
    logic [42:0]              r_ps, n_ps;
    logic signed [EW-1:0]     r_pe, n_pe;
    logic                     r_psg, n_psg;
    logic [23:0]              r_cs, n_cs;
    logic signed [EW-1:0]     r_ce, n_ce;
    logic                     r_csg, n_csg;
    logic [MW-1:0]            r_af, n_af, r_bf, n_bf;
    logic                     r_sa, n_sa, r_sb, n_sb;
    logic [MW-1:0]            r_m, n_m;
    logic signed [EW-1:0]     r_me, n_me;
    logic                     r_sgn, n_sgn;
    logic                     r_neg, n_neg;
    logic                     r_stk, n_stk;
    logic [7:0]               r_rexp, n_rexp;
    logic                     r_ovf, n_ovf;
    logic [31:0]              r_res, n_res;
    logic                     r_ovalid, n_ovalid;
    logic [31:0]              r_result, n_result;

    // operand unpack
    logic                     w_isgn;
    logic [31:0]              w_imag;
    logic                     w_hs;
    logic [4:0]               w_he;
    logic [9:0]               w_hm;
    logic [10:0]              w_hsig;
    logic signed [EW-1:0]     w_hlsb;
    logic                     w_hnan, w_hinf;
    logic [42:0]              w_prod;
    logic                     w_cs;
    logic [7:0]               w_ce;
    logic [22:0]              w_cm;
    logic [23:0]              w_csig;
    logic signed [EW-1:0]     w_clsb;
    logic                     w_cnan, w_cinf, w_czero;
    logic                     w_rs;
    logic [7:0]               w_re;
    logic [22:0]              w_rm;
    logic [23:0]              w_rsig;
    logic signed [EW-1:0]     w_rlsb;
    logic                     w_rnan, w_rinf, w_rzero;
    logic [47:0]              w_mprod;
    logic                     w_pzero, w_psg;
    // alignment
    logic                     w_p_big;
    logic [42:0]              w_amag, w_bmag;
    logic signed [EW-1:0]     w_ea, w_eb, w_d, w_rsh_full;
    logic [5:0]               w_lsh, w_rsh;
    logic [107:0]             w_btmp;
    logic [MW-1:0]            w_afr, w_bfr;
    logic [MW-1:0]            w_sum;
    logic [MW:0]              w_diff;
    // rounding
    logic signed [EW-1:0]     w_be, w_dfull;
    logic [4:0]               w_dsh;
    logic [MW+31:0]           w_dtmp;
    logic [23:0]              w_q;
    logic                     w_rb, w_st, w_up;
    logic [31:0]              w_mag32;

    assign w_isgn = r_ent.int_sum[31];
    assign w_imag = w_isgn ? (~r_ent.int_sum + 32'd1) : r_ent.int_sum;
    assign w_hs   = r_ent.group_scale[15];
    assign w_he   = r_ent.group_scale[14:10];
    assign w_hm   = r_ent.group_scale[9:0];
    assign w_hsig = {(w_he != 5'd0), w_hm};
    assign w_hlsb = (w_he == 5'd0) ? EW'(-24) : EW'(int'(w_he) - 25);
    assign w_hnan = (w_he == 5'h1F) && (w_hm != '0);
    assign w_hinf = (w_he == 5'h1F) && (w_hm == '0);
    assign w_prod = w_imag * w_hsig;
    assign w_pzero = (w_imag == '0) || (w_hsig == '0);
    assign w_psg  = w_isgn ^ w_hs;

    assign w_cs    = r_fsum[31];
    assign w_ce    = r_fsum[30:23];
    assign w_cm    = r_fsum[22:0];
    assign w_csig  = {(w_ce != 8'd0), w_cm};
    assign w_clsb  = (w_ce == 8'd0) ? EW'(-149) : EW'(int'(w_ce) - 150);
    assign w_cnan  = (w_ce == 8'hFF) && (w_cm != '0);
    assign w_cinf  = (w_ce == 8'hFF) && (w_cm == '0);
    assign w_czero = (w_ce == 8'd0) && (w_cm == '0);

    assign w_rs    = r_ent.row_scale[31];
    assign w_re    = r_ent.row_scale[30:23];
    assign w_rm    = r_ent.row_scale[22:0];
    assign w_rsig  = {(w_re != 8'd0), w_rm};
    assign w_rlsb  = (w_re == 8'd0) ? EW'(-149) : EW'(int'(w_re) - 150);
    assign w_rnan  = (w_re == 8'hFF) && (w_rm != '0);
    assign w_rinf  = (w_re == 8'hFF) && (w_rm == '0);
    assign w_rzero = (w_re == 8'd0) && (w_rm == '0);
    assign w_mprod = w_csig * w_rsig;

    // larger lsb exponent goes left, the other right with a sticky jam
    assign w_p_big    = (r_pe >= r_ce);
    assign w_amag     = w_p_big ? r_ps : 43'(r_cs);
    assign w_bmag     = w_p_big ? 43'(r_cs) : r_ps;
    assign w_ea       = w_p_big ? r_pe : r_ce;
    assign w_eb       = w_p_big ? r_ce : r_pe;
    assign w_d        = w_ea - w_eb;
    assign w_lsh      = (w_d > 48) ? 6'd48 : w_d[5:0];
    assign w_rsh_full = w_d - EW'(w_lsh);
    assign w_rsh      = (w_rsh_full > 63) ? 6'd63 : w_rsh_full[5:0];
    assign w_afr      = MW'(w_amag) << (7'(w_lsh) + 7'd1);
    assign w_btmp     = {w_bmag, 1'b0, 64'd0} >> w_rsh;
    assign w_bfr      = MW'(w_btmp[107:64]) | MW'(|w_btmp[63:0]);

    assign w_sum  = r_af + r_bf;
    assign w_diff = {1'b0, r_af} - {1'b0, r_bf};

    assign w_be    = r_me + EW'(MW + 126);
    assign w_dfull = EW'(1) - w_be;
    assign w_dsh   = (w_be > 0) ? 5'd0 : ((w_dfull > 26) ? 5'd26 : w_dfull[4:0]);
    assign w_dtmp  = {r_m, 32'd0} >> w_dsh;

    assign w_q     = r_m[MW-1 -: 24];
    assign w_rb    = r_m[MW-25];
    assign w_st    = (|r_m[MW-26:0]) || r_stk;
    assign w_up    = w_rb && (w_st || w_q[0]);
    assign w_mag32 = {1'b0, r_rexp, 23'd0} + 32'(w_q) + 32'(w_up);

    assign o_valid  = r_ovalid;
    assign o_result = r_result;
    assign o_busy   = (r_state != BK_IDLE);

    always_comb begin
        n_state  = r_state;
        n_ent    = r_ent;
        n_fsum   = r_fsum;
        n_is_mul = r_is_mul;
        n_ps     = r_ps;
        n_pe     = r_pe;
        n_psg    = r_psg;
        n_cs     = r_cs;
        n_ce     = r_ce;
        n_csg    = r_csg;
        n_af     = r_af;
        n_bf     = r_bf;
        n_sa     = r_sa;
        n_sb     = r_sb;
        n_m      = r_m;
        n_me     = r_me;
        n_sgn    = r_sgn;
        n_neg    = r_neg;
        n_stk    = r_stk;
        n_rexp   = r_rexp;
        n_ovf    = r_ovf;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        n_result = r_result;
        o_pop    = 1'b0;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    o_pop    = 1'b1;
                    n_ent    = i_entry;
                    n_is_mul = 1'b0;
                    n_state  = BK_PROD;
                end
            end
            BK_PROD: begin
                n_ps    = w_prod;
                n_pe    = w_pzero ? EW'(ZERO_LSB) : w_hlsb;
                n_psg   = w_psg;
                n_cs    = w_csig;
                n_ce    = w_czero ? EW'(ZERO_LSB) : w_clsb;
                n_csg   = w_cs;
                n_state = BK_DONE;
                if (w_hnan || w_cnan || (w_hinf && (w_imag == '0))) begin
                    n_res = QNAN32;
                end else if (w_hinf && w_cinf && (w_psg != w_cs)) begin
                    n_res = QNAN32;
                end else if (w_hinf) begin
                    n_res = {w_psg, POS_INF32[30:0]};
                end else if (w_cinf) begin
                    n_res = {w_cs, POS_INF32[30:0]};
                end else if (w_pzero && w_czero) begin
                    n_res = {w_psg && w_cs, 31'd0};
                end else begin
                    n_state = BK_ALIGN;
                end
            end
            BK_ALIGN: begin
                n_af    = w_afr;
                n_bf    = w_bfr;
                n_sa    = w_p_big ? r_psg : r_csg;
                n_sb    = w_p_big ? r_csg : r_psg;
                n_me    = w_ea - EW'(w_lsh) - EW'(1);
                n_state = BK_ADD;
            end
            BK_ADD: begin
                n_sgn = r_sa;
                if (r_sa == r_sb) begin
                    n_m   = w_sum;
                    n_neg = 1'b0;
                end else begin
                    n_m   = w_diff[MW-1:0];
                    n_neg = w_diff[MW];
                end
                n_state = BK_NEG;
            end
            BK_NEG: begin
                n_m     = r_neg ? (~r_m + MW'(1)) : r_m;
                n_sgn   = r_sgn ^ r_neg;
                n_state = BK_NORM;
            end
            BK_NORM: begin
                // exact cancellation gives +0
                if (r_m == '0) begin
                    n_res   = '0;
                    n_state = BK_DONE;
                end else if (r_m[MW-1 -: 8] == '0) begin
                    n_m  = r_m << 8;
                    n_me = r_me - EW'(8);
                end else if (!r_m[MW-1]) begin
                    n_m  = r_m << 1;
                    n_me = r_me - EW'(1);
                end else begin
                    n_state = BK_DENORM;
                end
            end
            BK_DENORM: begin
                n_m     = w_dtmp[MW+31:32];
                n_stk   = |w_dtmp[31:0];
                n_rexp  = (w_be > 0) ? w_be[7:0] - 8'd1 : 8'd0;
                n_ovf   = (w_be >= 256);
                n_state = BK_PACK;
            end
            BK_PACK: begin
                if (r_ovf || (w_mag32 >= POS_INF32)) begin
                    n_res = {r_sgn, POS_INF32[30:0]};
                end else begin
                    n_res = {r_sgn, w_mag32[30:0]};
                end
                n_state = BK_DONE;
            end
            BK_DONE: begin
                if (!r_is_mul) begin
                    n_fsum  = r_res;
                    n_state = r_ent.last ? BK_MULP : BK_IDLE;
                end else if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_result = r_res;
                    n_fsum   = '0;
                    n_state  = BK_IDLE;
                end
            end
            BK_MULP: begin
                n_is_mul = 1'b1;
                n_sgn    = w_cs ^ w_rs;
                n_m      = MW'(w_mprod);
                n_me     = w_clsb + w_rlsb;
                n_state  = BK_DONE;
                if (w_cnan || w_rnan || (w_cinf && w_rzero) || (w_rinf && w_czero)) begin
                    n_res = QNAN32;
                end else if (w_cinf || w_rinf) begin
                    n_res = {w_cs ^ w_rs, POS_INF32[30:0]};
                end else if (w_czero || w_rzero) begin
                    n_res = {w_cs ^ w_rs, 31'd0};
                end else begin
                    n_state = BK_NORM;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_fsum   <= '0;
            r_is_mul <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fsum   <= n_fsum;
            r_is_mul <= n_is_mul;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent    <= n_ent;
        r_ps     <= n_ps;
        r_pe     <= n_pe;
        r_psg    <= n_psg;
        r_cs     <= n_cs;
        r_ce     <= n_ce;
        r_csg    <= n_csg;
        r_af     <= n_af;
        r_bf     <= n_bf;
        r_sa     <= n_sa;
        r_sb     <= n_sb;
        r_m      <= n_m;
        r_me     <= n_me;
        r_sgn    <= n_sgn;
        r_neg    <= n_neg;
        r_stk    <= n_stk;
        r_rexp   <= n_rexp;
        r_ovf    <= n_ovf;
        r_res    <= n_res;
        r_result <= n_result;
    end

endmodule
`default_nettype wire

// ===== rtl/int4_grouped_scaled_dot_product.sv =====
// Top level of the int4 grouped scaled dot product block: config port, front, queue, back.
// Depends on i4gsdp_pkg, i4gsdp_front, i4gsdp_fifo, i4gsdp_back, assert_macros.svh.
//
// Usage:
//   Input channel (i_valid / o_ready): one beat is one chunk of four int8 activations
//   and four int4 weight nibbles, plus the group's fp16 scale, the fp32 row scale and
//   a last-chunk flag. The integer MAC takes one beat per cycle.
//   Output channel (o_valid / i_ready): one beat per dot product, the fp32 result,
//   sent only for a beat with last_chunk set.
//   Config: APB-style port, register group_chunks at address 0 (group length in
//   units of 64 k values, reset value 1). Write it only while the block is idle.
// Float engine:
//   A beat that closes a group is queued for the float engine, which pops an entry only
//   in IDLE and forms the product; special operands go straight to DONE, else ALIGN, ADD,
//   NEG, a NORM loop, DENORM, PACK, DONE; a last beat then runs MULP for the row scale.
//   The front keeps taking one beat per cycle while the four-entry drain queue has
//   room; o_ready drops only when the queue is full.
// Reset: synchronous, active low; clears the accumulators, the queue count and the output valid.
// Stall: while the receiver holds i_ready low the result stays in the output register;
//   the back end waits before writing the next result, and the queue fills behind it.
`default_nettype none
`include "assert_macros.svh"
module int4_grouped_scaled_dot_product (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i4gsdp_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [7:0]                   i_act0,
    input  logic signed [7:0]                   i_act1,
    input  logic signed [7:0]                   i_act2,
    input  logic signed [7:0]                   i_act3,
    input  logic [3:0]                          i_wnib0,
    input  logic [3:0]                          i_wnib1,
    input  logic [3:0]                          i_wnib2,
    input  logic [3:0]                          i_wnib3,
    input  logic [15:0]                         i_group_scale,
    input  logic [31:0]                         i_row_scale,
    input  logic                                i_last_chunk,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [31:0]                         o_result
);
    import i4gsdp_pkg::*;

    logic [GC_W-1:0] r_group_chunks;
    logic            w_push;
    logic            w_pop;
    t_drain          w_push_entry;
    t_drain          w_head_entry;
    t_q_stat         w_qstat;
    logic            w_bk_busy;
    logic            w_sel_gc;

    // Config port: zero wait states; decode on the word index only.
    assign pready   = 1'b1;
    assign w_sel_gc = (paddr[2] == REG_GROUP_CHUNKS);
    assign prdata   = w_sel_gc ? 32'(r_group_chunks) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_chunks <= GC_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_gc) begin
            r_group_chunks <= pwdata[GC_W-1:0];
        end
    end

    // Front: MAC one chunk per beat, push a drain request when a group closes.
    i4gsdp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_act0         (i_act0),
        .i_act1         (i_act1),
        .i_act2         (i_act2),
        .i_act3         (i_act3),
        .i_wnib0        (i_wnib0),
        .i_wnib1        (i_wnib1),
        .i_wnib2        (i_wnib2),
        .i_wnib3        (i_wnib3),
        .i_group_scale  (i_group_scale),
        .i_row_scale    (i_row_scale),
        .i_last_chunk   (i_last_chunk),
        .i_group_chunks (r_group_chunks),
        .i_full         (w_qstat.full),
        .o_push         (w_push),
        .o_entry        (w_push_entry)
    );

    // Queue: decouple the one-beat-per-cycle MAC from the multi-cycle float engine.
    i4gsdp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_stat  (w_qstat)
    );

    // Back: group FMA into the running float sum, row-scale multiply on the last beat.
    i4gsdp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_qstat.empty),
        .o_pop    (w_pop),
        .i_entry  (w_head_entry),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result),
        .o_busy   (w_bk_busy)
    );

    `ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, w_pop, !w_qstat.empty, "pop from empty queue")
    `ASSERT_IMPL(a_q_bound, i_clk, i_rst_n, 1'b1, w_qstat.count <= QCNT_W'(QDEPTH), "queue overrun")
    `ASSERT_NEXT(a_pop_busy, i_clk, i_rst_n, w_pop, w_bk_busy, "back end idle after pop")

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for int4_grouped_scaled_dot_product.
// Predicts each fp32 result (or takes it from a directed row) and compares output beats in order.
// Depends only on the RTL of the block and its package i4gsdp_pkg.
`timescale 1ns / 1ps
module tb;
    import i4gsdp_pkg::*;

    typedef struct {
        logic signed [7:0] act[LANES];
        logic [3:0]        wnib[LANES];
        logic [15:0]       gscale;
        logic [31:0]       rscale;
        logic              last;
        bit                typed;   // expected result given in the row
        logic [31:0]       want;
    } t_chunk;

    localparam int WATCHDOG = 4000;
    localparam int DRAIN_WAIT = 80;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic i_valid, o_ready, o_valid, i_ready;
    logic signed [7:0] i_act0, i_act1, i_act2, i_act3;
    logic [3:0] i_wnib0, i_wnib1, i_wnib2, i_wnib3;
    logic [15:0] i_group_scale;
    logic [31:0] i_row_scale, o_result;
    logic i_last_chunk;

    int4_grouped_scaled_dot_product DUT (.*);

    // Predictor state of the block
    logic [GC_W-1:0] group_len_reg;
    int              int_acc;
    logic [31:0]     run_sum;
    int              chunks_seen;
    logic [31:0]     result_q[$];
    int              errors;
    bit              quiet;
    int              idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---------------- float arithmetic at single precision ----------------
    function automatic logic [31:0] half_to_single(logic [15:0] h);
        logic [9:0] m;
        logic [10:0] mm;
        int ex;
        if (h[14:10] == 5'd31) return {h[15], 8'hFF, h[9:0], 13'd0};
        if (h[14:10] == 5'd0) begin
            if (h[9:0] == 10'd0) return {h[15], 31'd0};
            mm = {1'b0, h[9:0]};
            ex = -14;
            while (!mm[10]) begin
                mm = mm << 1;
                ex--;
            end
            m = mm[9:0];
            return {h[15], 8'(ex + 127), m, 13'd0};
        end
        return {h[15], 8'(h[14:10] + 112), h[9:0], 13'd0};
    endfunction

    function automatic real single_to_real(logic [31:0] f);
        logic [23:0] mm;
        int ex;
        if (f[30:23] == 8'hFF) return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'd0});
        if (f[30:23] == 8'h00) begin
            if (f[22:0] == 23'd0) return $bitstoreal({f[31], 63'd0});
            mm = {1'b0, f[22:0]};
            ex = -126;
            while (!mm[23]) begin
                mm = mm << 1;
                ex--;
            end
            return $bitstoreal({f[31], 11'(ex + 1023), mm[22:0], 29'd0});
        end
        return $bitstoreal({f[31], 11'(f[30:23] + 896), f[22:0], 29'd0});
    endfunction

    // Round to nearest even; every NaN becomes the canonical quiet NaN.
    function automatic logic [31:0] real_to_single(real d);
        logic [63:0] b, m, q, rem, hlf;
        logic [31:0] sgn, biased;
        int ex, sh;
        b = $realtobits(d);
        sgn = {b[63], 31'd0};
        m = {12'd0, b[51:0]};
        if (b[62:52] == 11'h7FF) return (m != 0) ? QNAN32 : (sgn | POS_INF32);
        if (b[62:52] == 11'd0) return sgn;
        ex = int'(b[62:52]) - 1023;
        if (ex > 127) return sgn | POS_INF32;
        m[52] = 1'b1;
        sh = 29;
        if (ex < -126) sh += -126 - ex;
        if (sh > 60) sh = 60;
        q = m >> sh;
        rem = m & ((64'd1 << sh) - 64'd1);
        hlf = 64'd1 << (sh - 1);
        if (rem > hlf || (rem == hlf && q[0])) q++;
        if (ex < -126) return sgn | q[31:0];
        biased = (32'(ex + 127) << 23) + q[31:0] - 32'h0080_0000;
        if (biased >= POS_INF32) return sgn | POS_INF32;
        return sgn | biased;
    endfunction

    function automatic bit is_finite(real d);
        logic [63:0] b;
        b = $realtobits(d);
        return b[62:52] != 11'h7FF;
    endfunction

    // a*b + c with a single rounding: fix the double sum's sticky bit, then round.
    function automatic logic [31:0] fused_mac(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        real p, dc, s, bb, err;
        logic [63:0] sb;
        p = single_to_real(a) * single_to_real(b);
        dc = single_to_real(c);
        if (!is_finite(p) || !is_finite(dc)) return real_to_single(p + dc);
        s = p + dc;
        bb = s - p;
        err = (p - (s - bb)) + (dc - bb);
        if (err != 0.0) begin
            sb = $realtobits(s);
            if (!sb[0]) begin
                if ((err > 0.0) == (s > 0.0)) sb++;
                else sb--;
                s = $bitstoreal(sb);
            end
        end
        return real_to_single(s);
    endfunction

    // Advance the predictor by one accepted chunk; push the result on a last chunk.
    task automatic predict_chunk(t_chunk c);
        int g, per_group;
        g = int'(group_len_reg);
        if (g < 1) g = 1;
        if (g > GC_MAX) g = GC_MAX;
        per_group = g * CHUNK_K / LANES;
        for (int i = 0; i < LANES; i++)
            int_acc += int'(c.act[i]) * int'($signed(c.wnib[i]));
        chunks_seen++;
        if (chunks_seen >= per_group || c.last) begin
            run_sum = fused_mac(real_to_single($itor(int_acc)),
                                half_to_single(c.gscale), run_sum);
            int_acc = 0;
            chunks_seen = 0;
        end
        if (c.last) begin
            result_q.push_back(c.typed ? c.want
                : real_to_single(single_to_real(run_sum) * single_to_real(c.rscale)));
            run_sum = 32'd0;
        end
    endtask

    // ---------------- drivers ----------------
    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        group_len_reg = data[GC_W-1:0];
    endtask

    task automatic send_chunk(t_chunk c);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_act0 <= c.act[0];
        i_act1 <= c.act[1];
        i_act2 <= c.act[2];
        i_act3 <= c.act[3];
        i_wnib0 <= c.wnib[0];
        i_wnib1 <= c.wnib[1];
        i_wnib2 <= c.wnib[2];
        i_wnib3 <= c.wnib[3];
        i_group_scale <= c.gscale;
        i_row_scale <= c.rscale;
        i_last_chunk <= c.last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_chunk(c);
    endtask

    // Drop valid, wait for every result, then let the float engine settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic t_chunk rand_chunk(bit last);
        t_chunk c;
        for (int i = 0; i < LANES; i++) begin
            c.act[i] = 8'($urandom);
            c.wnib[i] = 4'($urandom);
        end
        // Mostly moderate scales; sometimes any pattern (inf, NaN, subnormal).
        if ($urandom_range(0, 15) == 0) c.gscale = 16'($urandom);
        else c.gscale = {1'($urandom), 5'($urandom_range(8, 20)), 10'($urandom)};
        if ($urandom_range(0, 15) == 0) c.rscale = $urandom;
        else c.rscale = {1'($urandom), 8'($urandom_range(100, 140)), 23'($urandom)};
        c.last = last;
        c.typed = 1'b0;
        c.want = 32'd0;
        return c;
    endfunction

    task automatic send_product(int len);
        for (int j = 0; j < len; j++) send_chunk(rand_chunk(j == len - 1));
    endtask

    task automatic random_products(int n_chunks, int max_len);
        int sent, len;
        sent = 0;
        while (sent < n_chunks) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, max_len)
                                              : $urandom_range(1, 6);
            send_product(len);
            sent += len;
        end
    endtask

    function automatic t_chunk row(int a, int w, logic [15:0] gs, logic [31:0] rs,
                                   bit last, bit typed, logic [31:0] want);
        t_chunk c;
        for (int i = 0; i < LANES; i++) begin
            c.act[i] = 8'(a);
            c.wnib[i] = 4'(w);
        end
        c.gscale = gs;
        c.rscale = rs;
        c.last = last;
        c.typed = typed;
        c.want = want;
        return c;
    endfunction

    // ---------------- receiver and checker ----------------
    int stall_left;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (result_q.size() == 0) report("unexpected result", o_result, 32'd0);
            else begin
                logic [31:0] want;
                want = result_q.pop_front();
                if (o_result !== want) report("result", o_result, want);
            end
        end
    end

    // Watchdog: count cycles with no beat on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("FAIL int4_grouped_scaled_dot_product");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    t_chunk directed[$];
    initial begin
        errors = 0;
        quiet = 1'b0;
        idle_cycles = 0;
        stall_left = 0;
        group_len_reg = GC_RESET;
        int_acc = 0;
        run_sum = 32'd0;
        chunks_seen = 0;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= 32'd0;
        i_valid <= 1'b0;
        i_ready <= 1'b0;
        i_act0 <= '0;
        i_act1 <= '0;
        i_act2 <= '0;
        i_act3 <= '0;
        i_wnib0 <= '0;
        i_wnib1 <= '0;
        i_wnib2 <= '0;
        i_wnib3 <= '0;
        i_group_scale <= '0;
        i_row_scale <= '0;
        i_last_chunk <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: zero, extremes, partial group, specials.
        directed.push_back(row(0, 0, 16'h3C00, 32'h3F80_0000, 1, 1, 32'h0000_0000));
        directed.push_back(row(-128, 8, 16'h3C00, 32'h3F80_0000, 1, 1, 32'h4580_0000));
        directed.push_back(row(127, 7, 16'h3C00, 32'h3F80_0000, 0, 0, 0));
        directed.push_back(row(-128, 7, 16'h0001, 32'h0000_0001, 1, 0, 0));
        directed.push_back(row(1, 1, 16'h7C00, 32'h3F80_0000, 1, 1, POS_INF32));
        directed.push_back(row(1, 1, 16'h7E00, 32'h3F80_0000, 1, 1, QNAN32));
        directed.push_back(row(0, 0, 16'h3C00, POS_INF32, 1, 1, QNAN32));
        directed.push_back(row(127, 15, 16'h7BFF, 32'h7F7F_FFFF, 1, 0, 0));
        directed.push_back(row(-1, 9, 16'hBC00, 32'h8000_0001, 1, 0, 0));
        directed.push_back(row(-127, 1, 16'h03FF, 32'h7F00_0000, 0, 0, 0));
        directed.push_back(row(64, 4, 16'hFC00, 32'h3F80_0000, 1, 0, 0));
        directed.push_back(row(-128, 15, 16'h8400, 32'h0080_0000, 1, 0, 0));
        foreach (directed[i]) send_chunk(directed[i]);
        // One full group at the reset length, closed exactly on the last chunk.
        send_product(CHUNK_K / LANES);

        random_products(100, 40);
        drain();
        reg_write(REG_GROUP_CHUNKS, 32'd3);
        random_products(90, 60);
        drain();
        reg_write(REG_GROUP_CHUNKS, 32'd0);   // acts as one chunk of 64
        random_products(40, 40);
        drain();
        reg_write(REG_GROUP_CHUNKS, 32'h7F);  // above range, acts as 64
        send_product(GC_MAX * CHUNK_K / LANES + 6);
        random_products(8, 8);
        drain();
        reg_write(REG_GROUP_CHUNKS, 32'd1);
        quiet = 1'b1;                         // no idling from here on
        random_products(50, 40);

        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) $display("PASS int4_grouped_scaled_dot_product");
        else $display("FAIL int4_grouped_scaled_dot_product");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/i4gsdp_pkg.sv
rtl/i4gsdp_front.sv
rtl/i4gsdp_fifo.sv
rtl/i4gsdp_back.sv
rtl/int4_grouped_scaled_dot_product.sv
tb/tb.sv
